// ===== rtl/core/ukt_pkg.sv =====
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared constants, operation and status codes, and the command and status
// bundles that pass between the unordered key table controller and datapath.
// ----------------------------------------------------------------------------
package ukt_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int KEY_W      = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 7;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic start;     // latch request, reset scan pointer
    logic scan;      // walk the key store
    logic insert;    // append or report full
    logic nop;       // unused operation code
    logic move_rd;   // read last entry
    logic move_wr;   // write last entry into the hole, drop count
    logic load_out;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            miss;
    logic            out_free;
  } sts_t;

endpackage

// ===== rtl/core/ukt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ukt_ctrl
// Sequencer for the unordered key table: dispatches each transaction to a
// scan, insert or remove sequence and hands the result to the output stage.
// ----------------------------------------------------------------------------
module ukt_ctrl
  import ukt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_INSERT   = 7'b0001000,
    S_MOVE_RD  = 7'b0010000,
    S_MOVE_WR  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.op == OP_INSERT) begin
          state_next = S_INSERT;
        end else if (sts.op == OP_SEARCH || sts.op == OP_REMOVE) begin
          state_next = S_SCAN;
        end else begin
          cmd.nop    = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_next = (sts.op == OP_REMOVE) ? S_MOVE_RD : S_DONE;
        end else if (sts.miss) begin
          state_next = S_DONE;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_next  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ukt_datapath.sv =====
// ----------------------------------------------------------------------------
// ukt_datapath
// Key and data stores, fill count, capacity register, request latch, the
// pipelined key scan and the output register of the unordered key table.
// ----------------------------------------------------------------------------
module ukt_datapath
  import ukt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [OP_W-1:0]       op,
  input  logic [KEY_W-1:0]      key,
  input  logic [DATA_WIDTH-1:0] entry_data,
  input  logic                  cfg_valid,
  input  logic [CAP_W-1:0]      cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ST_W-1:0]       status,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic [CNT_W-1:0]      entry_count
);

  logic [KEY_W-1:0]      key_mem  [DEPTH];
  logic [DATA_WIDTH-1:0] data_mem [DEPTH];

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      count;
  logic [OP_W-1:0]       req_op;
  logic [KEY_W-1:0]      req_key;
  logic [DATA_WIDTH-1:0] req_data;

  logic [CNT_W-1:0]      scan_idx;
  logic                  rd_v;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [IDX_W-1:0]      slot;
  logic [KEY_W-1:0]      key_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic [ST_W-1:0]       res_status;
  logic [DATA_WIDTH-1:0] res_data;

  logic [CAP_W-1:0]      lim;
  logic                  full;
  logic                  issue;
  logic                  hit;
  logic                  miss;
  logic [IDX_W-1:0]      last_idx;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_W-1:0]      wr_key;
  logic [DATA_WIDTH-1:0] wr_data;

  // effective limit saturates at the store depth
  assign lim      = (capacity > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity;
  assign full     = (CAP_W'(count) >= lim) || (count >= CNT_W'(DEPTH));
  assign issue    = cmd.scan && (scan_idx < count);
  assign hit      = rd_v && (key_q == req_key);
  assign miss     = !rd_v && (scan_idx >= count);
  assign last_idx = IDX_W'(count - CNT_W'(1));

  assign rd_addr  = cmd.move_rd ? last_idx : scan_idx[IDX_W-1:0];
  assign mem_we   = (cmd.insert && !full) || cmd.move_wr;
  assign wr_addr  = cmd.move_wr ? slot : count[IDX_W-1:0];
  assign wr_key   = cmd.move_wr ? key_q : req_key;
  assign wr_data  = cmd.move_wr ? data_q : req_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr]  <= wr_key;
      data_mem[wr_addr] <= wr_data;
    end
    key_q  <= key_mem[rd_addr];
    data_q <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op   <= op;
      req_key  <= key;
      req_data <= entry_data;
    end
  end

  // scan pipeline: one read issued per cycle, compared against the key in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_v     <= 1'b0;
    end else if (cmd.start) begin
      scan_idx <= '0;
      rd_v     <= 1'b0;
    end else if (cmd.scan) begin
      rd_v <= issue;
      if (issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx_q <= scan_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && hit) begin
      slot       <= rd_idx_q;
      res_status <= ST_OK;
      res_data   <= data_q;
    end else if (cmd.scan && miss) begin
      res_status <= ST_MISS;
      res_data   <= '0;
    end else if (cmd.insert) begin
      res_status <= full ? ST_FULL : ST_OK;
      res_data   <= '0;
    end else if (cmd.nop) begin
      res_status <= ST_OK;
      res_data   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert && !full) begin
      count <= count + CNT_W'(1);
    end else if (cmd.move_wr) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= res_status;
      out_data    <= res_data;
      entry_count <= count;
    end
  end

  assign sts.op       = req_op;
  assign sts.hit      = hit;
  assign sts.miss     = miss;
  assign sts.out_free = !out_valid || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above store depth");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && hit) |-> (CNT_W'(rd_idx_q) < count))
    else $error("scan hit outside filled slots");

  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.move_wr |-> (count != '0))
    else $error("remove on empty table");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.insert && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not advance fill count");

endmodule

// ===== rtl/core/unordered_key_table_unit.sv =====
// ----------------------------------------------------------------------------
// unordered_key_table_unit
// Unsorted key/data table with search, append insert and swap remove.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Insert appends without a scan;
// search and remove walk the filled slots through the key store read port
// one slot per cycle, and remove then reads the last entry and writes it
// into the hole. A new transaction is accepted while the previous result
// still waits in the output register. The capacity register resets to 64
// and may be written whenever the table is idle.
// ----------------------------------------------------------------------------
module unordered_key_table_unit
  import ukt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [KEY_W-1:0]      key,
  input  logic [DATA_WIDTH-1:0] entry_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ST_W-1:0]       status,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic [CNT_W-1:0]      entry_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ukt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ukt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .key         (key),
    .entry_data  (entry_data),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_data    (out_data),
    .entry_count (entry_count)
  );

endmodule

// ===== tb/sv/ukt_table_checker.sv =====
// ----------------------------------------------------------------------------
// ukt_table_checker
// Watches the request, reply and capacity channels of the unordered key
// table, keeps a shadow copy of the table and compares every reply in order.
// ----------------------------------------------------------------------------
module ukt_table_checker
  import ukt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [KEY_W-1:0]      key,
  input  logic [DATA_WIDTH-1:0] entry_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ST_W-1:0]       status,
  input  logic [DATA_WIDTH-1:0] out_data,
  input  logic [CNT_W-1:0]      entry_count,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data,
  output int                    replies_pending,
  output int                    error_count
);

  typedef struct packed {
    logic [ST_W-1:0]       status;
    logic [DATA_WIDTH-1:0] data;
    logic [CNT_W-1:0]      count;
  } table_reply_t;

  logic [KEY_W-1:0]      shadow_keys [DEPTH];
  logic [DATA_WIDTH-1:0] shadow_data [DEPTH];
  int                    shadow_fill;
  logic [CAP_W-1:0]      shadow_cap;
  table_reply_t          replies_due [$];
  int                    errors;

  initial begin
    replies_pending = 0;
    error_count     = 0;
    errors          = 0;
    shadow_fill     = 0;
    shadow_cap      = CAP_RESET;
  end

  // applies one request to the shadow table and returns the reply it earns
  function automatic table_reply_t apply_table_op(logic [OP_W-1:0]       opc,
                                                  logic [KEY_W-1:0]      k,
                                                  logic [DATA_WIDTH-1:0] d);
    table_reply_t r;
    int           hit_slot;
    int           limit;
    r        = '0;
    r.status = ST_OK;
    hit_slot = -1;
    limit    = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    // walk downward so the lowest matching slot wins
    for (int i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_keys[i] == k) hit_slot = i;
    end
    case (opc)
      OP_SEARCH: begin
        if (hit_slot < 0) r.status = ST_MISS;
        else r.data = shadow_data[hit_slot];
      end
      OP_INSERT: begin
        if (shadow_fill >= limit || shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[shadow_fill] = k;
          shadow_data[shadow_fill] = d;
          shadow_fill++;
        end
      end
      OP_REMOVE: begin
        if (hit_slot < 0) begin
          r.status = ST_MISS;
        end else begin
          r.data = shadow_data[hit_slot];
          // last entry fills the hole
          shadow_keys[hit_slot] = shadow_keys[shadow_fill - 1];
          shadow_data[hit_slot] = shadow_data[shadow_fill - 1];
          shadow_fill--;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic flag_error(string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  always @(posedge clk) begin : watch
    table_reply_t want;
    if (rst) begin
      shadow_fill = 0;
      shadow_cap  = CAP_RESET;
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) shadow_cap = cfg_data;
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          flag_error($sformatf("unexpected reply: status %0d data %h count %0d",
                               status, out_data, entry_count));
        end else begin
          want = replies_due.pop_front();
          if (want.status !== status || want.data !== out_data ||
              want.count !== entry_count)
            flag_error($sformatf(
              "reply mismatch: expected status %0d data %h count %0d, got %0d %h %0d",
              want.status, want.data, want.count, status, out_data, entry_count));
        end
      end
      if (in_valid && in_ready) replies_due.push_back(apply_table_op(op, key, entry_data));
    end
    replies_pending <= replies_due.size();
    error_count     <= errors;
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the unordered key table with directed and random search, insert and
// remove traffic under several capacity settings, with bursty requests and a
// stalling reply side; the checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb;
  import ukt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_PHASE  = 4;
  localparam int HOLD_CYCLES = 600;
  localparam int POOL_SIZE   = 12;

  // reply side pacing modes
  localparam int RX_ALWAYS = 0;
  localparam int RX_MOSTLY = 1;
  localparam int RX_SELDOM = 2;
  localparam int RX_PULSE  = 3;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       op         = OP_SEARCH;
  logic [KEY_W-1:0]      key        = '0;
  logic [DATA_WIDTH-1:0] entry_data = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [ST_W-1:0]       status;
  logic [DATA_WIDTH-1:0] out_data;
  logic [CNT_W-1:0]      entry_count;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data   = '0;

  int replies_pending;
  int error_count;
  int cycle_count = 0;
  int holds_asked = 0;
  int holds_seen  = 0;
  int hold_left   = 0;
  int rx_mode     = RX_ALWAYS;
  int rx_left     = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always #2 clk = ~clk;

  unordered_key_table_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .key(key), .entry_data(entry_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_data(out_data), .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ukt_table_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .key(key), .entry_data(entry_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_data(out_data), .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .replies_pending(replies_pending), .error_count(error_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // reply side: random pacing modes, plus a long hold-off when asked
  always @(posedge clk) begin
    if (holds_asked != holds_seen) begin
      holds_seen = holds_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(RX_ALWAYS, RX_PULSE);
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SELDOM: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= rx_left[2];
      endcase
    end
  end

  task automatic send_op(logic [OP_W-1:0] o, logic [KEY_W-1:0] k,
                         logic [DATA_WIDTH-1:0] d);
    op         <= o;
    key        <= k;
    entry_data <= d;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_idle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [OP_W-1:0] pick_op(int ins_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_UNUSED;
    if (roll < 3 + ins_pct * 97 / 100) return OP_INSERT;
    return ($urandom_range(0, 99) < 45) ? OP_SEARCH : OP_REMOVE;
  endfunction

  // mostly keys from a small pool so searches and removes hit
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_data();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int cap_plan [PHASES];
    int ins_plan [PHASES];
    int burst_left;

    cap_plan = '{64, 127, 1, 0, 64, 8, 0, 100, 32, 127, 0, 64};
    ins_plan = '{85, 90, 50, 40, 90, 50, 50, 30, 50, 90, 40, 20};
    cap_plan[6]  = $urandom_range(1, 64);
    cap_plan[10] = $urandom_range(0, 127);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table, extremes, duplicates, swap remove, removing the last slot
    send_op(OP_SEARCH, 32'h0000_0000, $urandom());
    send_op(OP_REMOVE, 32'hffff_ffff, $urandom());
    send_op(OP_UNUSED, 32'h0000_0000, 32'hffff_ffff);
    send_op(OP_INSERT, 32'h0000_0000, 32'hffff_ffff);
    send_op(OP_INSERT, 32'hffff_ffff, 32'h0000_0000);
    send_op(OP_INSERT, 32'h1234_5678, 32'ha5a5_a5a5);
    send_op(OP_INSERT, 32'h0000_0000, 32'h5a5a_5a5a);
    send_op(OP_SEARCH, 32'h0000_0000, $urandom());
    send_op(OP_SEARCH, 32'hffff_ffff, $urandom());
    send_op(OP_REMOVE, 32'h0000_0000, $urandom());
    send_op(OP_SEARCH, 32'h0000_0000, $urandom());
    send_op(OP_REMOVE, 32'h1234_5678, $urandom());
    send_op(OP_SEARCH, 32'h1234_5678, $urandom());
    send_op(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);

    // capacity zero, then capacity below the current count
    write_capacity(CAP_W'(0));
    send_op(OP_INSERT, 32'hdead_beef, 32'h0bad_f00d);
    send_op(OP_SEARCH, 32'hffff_ffff, $urandom());
    write_capacity(CAP_W'(1));
    send_op(OP_INSERT, 32'hdead_beef, 32'h0bad_f00d);
    send_op(OP_REMOVE, 32'hffff_ffff, $urandom());
    send_op(OP_REMOVE, 32'h0000_0000, $urandom());
    send_op(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    send_op(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    write_capacity(CAP_W'(127));
    send_op(OP_INSERT, 32'h0000_0001, 32'hffff_fffe);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(CAP_W'(cap_plan[ph]));
      key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom();
      burst_left = 0;
      if (ph == HOLD_PHASE) begin
        // keep offering while replies are held back so the input stalls
        holds_asked <= holds_asked + 1;
        burst_left = 48;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_op(pick_op(ins_plan[ph]), pick_key(), pick_data());
      end
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (error_count == 0 && replies_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
